@@ design/szpd_pkg.sv @@
// Shared types and constants of the smoothed z-score peak detector.
// No dependencies; used by the core, its window RAM users and the checker.
package szpd_pkg;

	// Register field and bus widths
	localparam int LEN_W  = 7;
	localparam int ZT_W   = 12;
	localparam int IW_W   = 9;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_WINDOW_LENGTH    = 2'd0;
	localparam logic [1:0] REG_Z_THRESHOLD      = 2'd1;
	localparam logic [1:0] REG_INFLUENCE_WEIGHT = 2'd2;

	// Register reset values
	localparam logic [LEN_W-1:0] WL_RESET = 7'd5;
	localparam logic [ZT_W-1:0]  ZT_RESET = 12'd896;
	localparam logic [IW_W-1:0]  IW_RESET = 9'd128;

	// Influence weight of one (Q1.8)
	localparam logic [IW_W-1:0] IW_ONE = 9'd256;

	// Peak flag codes
	localparam logic [1:0] FLAG_NONE = 2'b00;
	localparam logic [1:0] FLAG_POS  = 2'b01;
	localparam logic [1:0] FLAG_NEG  = 2'b11;
	localparam logic [1:0] FLAG_BAD  = 2'b10;

	// Sequencer states, one-hot
	typedef enum logic [18:0] {
		ST_IDLE = 19'h00001,
		ST_T2   = 19'h00002,
		ST_LX   = 19'h00004,
		ST_D    = 19'h00008,
		ST_DD   = 19'h00010,
		ST_QL   = 19'h00020,
		ST_QH   = 19'h00040,
		ST_VAR  = 19'h00080,
		ST_RL   = 19'h00100,
		ST_RH   = 19'h00200,
		ST_CMP  = 19'h00400,
		ST_W1   = 19'h00800,
		ST_W2   = 19'h01000,
		ST_FILT = 19'h02000,
		ST_OLD  = 19'h04000,
		ST_SQ   = 19'h08000,
		ST_UPD  = 19'h10000,
		ST_DIV  = 19'h20000,
		ST_OUT  = 19'h40000
	} state_t;

endpackage

@@ design/szpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module szpd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/smoothed_zscore_peak_detector_core.sv @@
// Smoothed z-score peak detector core: statistics, flag test, filter, mean divider.
// Depends on szpd_pkg and szpd_ram.
// Flow: one word at a time; warm-up words skip the statistics and flag test, unflagged words
//   skip the filter. A new word is taken only after the last one is loaded to the output,
//   which waits while a stalled output word is still offered.
//   All products share one multiplier; the mean uses a one-bit-per-cycle divider.
// Reset: asynchronous, active low; clears sums, fill count, pointer, last filtered value and
//   out_valid; sets reg defaults. Window RAM is not cleared; only written entries are read.
module smoothed_zscore_peak_detector_core #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            frame_start,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [1:0]               peak_flag,
	output logic                            ready_res,
	output logic signed [SAMPLE_BITS-1:0]   window_mean,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [szpd_pkg::ADDR_W-1:0]     paddr,
	input  logic [szpd_pkg::DATA_W-1:0]     pwdata,
	output logic [szpd_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int SB   = SAMPLE_BITS;
	localparam int LW   = szpd_pkg::LEN_W;
	localparam int AW   = $clog2(WINDOW_MAX);
	localparam int SW   = SB + LW;
	localparam int QW   = 2 * SB + 6;
	localparam int MW   = (SB + 8 > 24) ? SB + 8 : 24;
	localparam int PW   = 2 * MW;
	localparam int CW   = 3 * MW;
	localparam int NW   = SB + 10;
	localparam int CNTW = $clog2(SW + 1);

	szpd_pkg::state_t state_q;

	// configuration registers
	logic [LW-1:0]               wl_q;
	logic [szpd_pkg::ZT_W-1:0]   zt_q;
	logic [szpd_pkg::IW_W-1:0]   iw_q;

	// window statistics
	logic signed [SW-1:0]        sum_q;
	logic [QW-1:0]               sq_q;
	logic [LW-1:0]               fill_q;
	logic [AW-1:0]               wp_q;
	logic signed [SB-1:0]        last_q;

	// per-word working registers
	logic signed [SB-1:0]        x_q;
	logic signed [SB-1:0]        filt_q;
	logic                        fs_q;
	logic [LW-1:0]               len_q;
	logic                        rdy_q;
	logic [1:0]                  flag_q;
	logic                        pos_q;
	logic [MW-1:0]               t2_q;
	logic [MW-1:0]               d_q;
	logic [PW-1:0]               ss_q;
	logic [CW-1:0]               lhs_q;
	logic [PW-1:0]               acc_q;
	logic [PW-1:0]               var_q;
	logic signed [NW-1:0]        num_q;
	logic [PW-1:0]               fsq_q;
	logic [PW-1:0]               prod_q;

	// divider
	logic [SW-1:0]               dq_q;
	logic [LW-1:0]               rem_q;
	logic [LW-1:0]               n_q;
	logic                        neg_q;
	logic [CNTW-1:0]             cnt_q;

	logic                        ov_q;

	logic                        in_acc;
	logic                        cfg_wr;
	logic [1:0]                  cfg_idx;
	logic                        full;
	logic                        win_clr;

	logic [MW-1:0]               mul_a;
	logic [MW-1:0]               mul_b;
	logic [PW-1:0]               mul_p;

	logic [SB-1:0]               x_neg, x_abs;
	logic [SB-1:0]               last_neg, last_abs;
	logic [SB-1:0]               filt_neg, filt_abs;
	logic [SB-1:0]               rd_data, old_neg, old_abs;
	logic [SW-1:0]               sum_neg, sum_abs;
	logic [PW-1:0]               q_pad;
	logic [szpd_pkg::IW_W-1:0]   w_cl, w_inv;
	logic [LW-1:0]               len_w;

	logic [SW-1:0]               lx_m;
	logic signed [SW+1:0]        lx_s, dlt;
	logic [SW+1:0]               dlt_neg, d_abs;
	logic [CW-1:0]               lq, rhs;
	logic signed [NW-1:0]        term, num_w, num_sh;
	logic signed [SB-1:0]        old_s;
	logic signed [SW-1:0]        sum_new;
	logic [SW-1:0]               sum_new_neg;
	logic [PW-1:0]               oldsq;
	logic [LW:0]                 rsh;
	logic                        ge;
	logic [SW-1:0]               mean_neg, mean_w;

	assign pready   = 1'b1;
	assign in_stall = (state_q != szpd_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[3:2];
	assign out_valid = ov_q;
	assign full     = (fill_q >= len_q);
	assign win_clr  = (cfg_wr && cfg_idx == szpd_pkg::REG_WINDOW_LENGTH)
		|| (in_acc && frame_start);

	// effective window length
	always_comb begin
		if (wl_q < LW'(2)) begin
			len_w = LW'(2);
		end else if (int'(wl_q) > WINDOW_MAX) begin
			len_w = LW'(WINDOW_MAX);
		end else begin
			len_w = wl_q;
		end
	end

	// magnitudes for the unsigned multiplier
	assign x_neg    = -x_q;
	assign x_abs    = x_q[SB-1] ? x_neg : x_q;
	assign last_neg = -last_q;
	assign last_abs = last_q[SB-1] ? last_neg : last_q;
	assign filt_neg = -filt_q;
	assign filt_abs = filt_q[SB-1] ? filt_neg : filt_q;
	assign old_neg  = -rd_data;
	assign old_abs  = rd_data[SB-1] ? old_neg : rd_data;
	assign sum_neg  = -sum_q;
	assign sum_abs  = sum_q[SW-1] ? sum_neg : sum_q;
	assign q_pad    = PW'(sq_q);
	assign w_cl     = (iw_q > szpd_pkg::IW_ONE) ? szpd_pkg::IW_ONE : iw_q;
	assign w_inv    = szpd_pkg::IW_ONE - w_cl;

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			szpd_pkg::ST_T2: begin
				mul_a = MW'(zt_q);
				mul_b = MW'(zt_q);
			end
			szpd_pkg::ST_LX: begin
				mul_a = MW'(len_q);
				mul_b = MW'(x_abs);
			end
			szpd_pkg::ST_D: begin
				mul_a = MW'(sum_abs);
				mul_b = MW'(sum_abs);
			end
			szpd_pkg::ST_DD: begin
				mul_a = d_q;
				mul_b = d_q;
			end
			szpd_pkg::ST_QL: begin
				mul_a = MW'(len_q);
				mul_b = q_pad[MW-1:0];
			end
			szpd_pkg::ST_QH: begin
				mul_a = MW'(len_q);
				mul_b = q_pad[PW-1:MW];
			end
			szpd_pkg::ST_RL: begin
				mul_a = var_q[MW-1:0];
				mul_b = t2_q;
			end
			szpd_pkg::ST_RH: begin
				mul_a = var_q[PW-1:MW];
				mul_b = t2_q;
			end
			szpd_pkg::ST_W1: begin
				mul_a = MW'(w_cl);
				mul_b = MW'(x_abs);
			end
			szpd_pkg::ST_W2: begin
				mul_a = MW'(w_inv);
				mul_b = MW'(last_abs);
			end
			szpd_pkg::ST_OLD: begin
				mul_a = MW'(filt_abs);
				mul_b = MW'(filt_abs);
			end
			szpd_pkg::ST_SQ: begin
				mul_a = MW'(old_abs);
				mul_b = MW'(old_abs);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// product register after the multiplier
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
	end

	// distance of len*x from the sum
	assign lx_m    = prod_q[SW-1:0];
	assign lx_s    = x_q[SB-1] ? -$signed({2'b00, lx_m}) : $signed({2'b00, lx_m});
	assign dlt     = lx_s - (SW+2)'(sum_q);
	assign dlt_neg = -dlt;
	assign d_abs   = dlt[SW+1] ? dlt_neg : dlt;

	// recombine two partial products
	assign lq  = CW'(acc_q) + (CW'(prod_q) << MW);
	assign rhs = lq;

	// blended sample, rounded half up
	assign term   = x_q[SB-1] ? -$signed({1'b0, prod_q[NW-2:0]})
		: $signed({1'b0, prod_q[NW-2:0]});
	assign num_w  = last_q[SB-1] ? num_q - $signed({1'b0, prod_q[NW-2:0]})
		: num_q + $signed({1'b0, prod_q[NW-2:0]});
	assign num_sh = num_w >>> 8;

	// window update
	assign old_s       = full ? $signed(rd_data) : '0;
	assign oldsq       = full ? prod_q : '0;
	assign sum_new     = sum_q - SW'(old_s) + SW'(filt_q);
	assign sum_new_neg = -sum_new;

	// restoring divider step
	assign rsh = {rem_q, dq_q[SW-1]};
	assign ge  = (rsh >= {1'b0, n_q});

	assign mean_neg = -dq_q;
	assign mean_w   = neg_q ? mean_neg : dq_q;

	szpd_ram #(
		.WIDTH(SB),
		.DEPTH(WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (state_q == szpd_pkg::ST_UPD),
		.waddr (wp_q),
		.wdata (filt_q),
		.re    (state_q == szpd_pkg::ST_OLD),
		.raddr (wp_q),
		.rdata (rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= szpd_pkg::WL_RESET;
			zt_q <= szpd_pkg::ZT_RESET;
			iw_q <= szpd_pkg::IW_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				szpd_pkg::REG_WINDOW_LENGTH:    wl_q <= pwdata[LW-1:0];
				szpd_pkg::REG_Z_THRESHOLD:      zt_q <= pwdata[szpd_pkg::ZT_W-1:0];
				szpd_pkg::REG_INFLUENCE_WEIGHT: iw_q <= pwdata[szpd_pkg::IW_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			szpd_pkg::REG_WINDOW_LENGTH:    prdata = szpd_pkg::DATA_W'(wl_q);
			szpd_pkg::REG_Z_THRESHOLD:      prdata = szpd_pkg::DATA_W'(zt_q);
			szpd_pkg::REG_INFLUENCE_WEIGHT: prdata = szpd_pkg::DATA_W'(iw_q);
			default:                        prdata = '0;
		endcase
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= szpd_pkg::ST_IDLE;
			sum_q   <= '0;
			sq_q    <= '0;
			fill_q  <= '0;
			wp_q    <= '0;
			last_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			// output valid: set when a word is loaded, cleared when taken
			if (state_q == szpd_pkg::ST_OUT && !(ov_q && out_stall)) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			// window cleared on a length write or frame start, else slid on update
			if (win_clr) begin
				sum_q  <= '0;
				sq_q   <= '0;
				fill_q <= '0;
				wp_q   <= '0;
			end else if (state_q == szpd_pkg::ST_UPD) begin
				sum_q <= sum_new;
				sq_q  <= sq_q - QW'(oldsq) + QW'(fsq_q);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
				if (int'(wp_q) + 1 >= int'(len_q)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (state_q == szpd_pkg::ST_UPD) begin
				last_q <= filt_q;
			end
			case (state_q)
				szpd_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= szpd_pkg::ST_T2;
					end
				end
				szpd_pkg::ST_T2: begin
					state_q <= full ? szpd_pkg::ST_LX : szpd_pkg::ST_OLD;
				end
				szpd_pkg::ST_LX:  state_q <= szpd_pkg::ST_D;
				szpd_pkg::ST_D:   state_q <= szpd_pkg::ST_DD;
				szpd_pkg::ST_DD:  state_q <= szpd_pkg::ST_QL;
				szpd_pkg::ST_QL:  state_q <= szpd_pkg::ST_QH;
				szpd_pkg::ST_QH:  state_q <= szpd_pkg::ST_VAR;
				szpd_pkg::ST_VAR: state_q <= szpd_pkg::ST_RL;
				szpd_pkg::ST_RL:  state_q <= szpd_pkg::ST_RH;
				szpd_pkg::ST_RH:  state_q <= szpd_pkg::ST_CMP;
				szpd_pkg::ST_CMP: begin
					state_q <= (lhs_q > rhs) ? szpd_pkg::ST_W1 : szpd_pkg::ST_OLD;
				end
				szpd_pkg::ST_W1:   state_q <= szpd_pkg::ST_W2;
				szpd_pkg::ST_W2:   state_q <= szpd_pkg::ST_FILT;
				szpd_pkg::ST_FILT: state_q <= szpd_pkg::ST_OLD;
				szpd_pkg::ST_OLD:  state_q <= szpd_pkg::ST_SQ;
				szpd_pkg::ST_SQ:   state_q <= szpd_pkg::ST_UPD;
				szpd_pkg::ST_UPD:  state_q <= szpd_pkg::ST_DIV;
				szpd_pkg::ST_DIV: begin
					if (cnt_q == CNTW'(1)) begin
						state_q <= szpd_pkg::ST_OUT;
					end
				end
				szpd_pkg::ST_OUT: begin
					if (!(ov_q && out_stall)) begin
						state_q <= szpd_pkg::ST_IDLE;
					end
				end
				default: state_q <= szpd_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath working registers
	always_ff @(posedge clk) begin
		case (state_q)
			szpd_pkg::ST_IDLE: begin
				x_q    <= sample;
				filt_q <= sample;
				fs_q   <= frame_start;
				flag_q <= szpd_pkg::FLAG_NONE;
				len_q  <= len_w;
			end
			szpd_pkg::ST_T2: begin
				rdy_q <= full;
			end
			szpd_pkg::ST_LX: begin
				t2_q <= prod_q[MW-1:0];
			end
			szpd_pkg::ST_D: begin
				d_q   <= MW'(d_abs[SW:0]);
				pos_q <= !dlt[SW+1] && (dlt != '0);
			end
			szpd_pkg::ST_DD: begin
				ss_q <= prod_q;
			end
			szpd_pkg::ST_QL: begin
				lhs_q <= CW'(prod_q) << 16;
			end
			szpd_pkg::ST_QH: begin
				acc_q <= prod_q;
			end
			szpd_pkg::ST_VAR: begin
				var_q <= (lq > CW'(ss_q)) ? PW'(lq - CW'(ss_q)) : '0;
			end
			szpd_pkg::ST_RH: begin
				acc_q <= prod_q;
			end
			szpd_pkg::ST_W2: begin
				num_q <= term + NW'(128);
			end
			szpd_pkg::ST_FILT: begin
				filt_q <= num_sh[SB-1:0];
				flag_q <= pos_q ? szpd_pkg::FLAG_POS : szpd_pkg::FLAG_NEG;
			end
			szpd_pkg::ST_SQ: begin
				fsq_q <= prod_q;
			end
			szpd_pkg::ST_UPD: begin
				dq_q  <= sum_new[SW-1] ? sum_new_neg : sum_new;
				neg_q <= sum_new[SW-1];
				rem_q <= '0;
				n_q   <= full ? fill_q : fill_q + 1'b1;
				cnt_q <= CNTW'(SW);
			end
			szpd_pkg::ST_DIV: begin
				rem_q <= ge ? LW'(rsh - {1'b0, n_q}) : rsh[LW-1:0];
				dq_q  <= {dq_q[SW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			szpd_pkg::ST_OUT: begin
				if (!(ov_q && out_stall)) begin
					peak_flag   <= flag_q;
					ready_res   <= rdy_q && !(fs_q && 1'b0);
					window_mean <= mean_w[SB-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

@@ design/szpd_checker.sv @@
// Port-level checker for the smoothed z-score peak detector core, with its bind.
// Depends on szpd_pkg.
module szpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] peak_flag,
	input logic       ready_res
);

	// a stalled word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in progress");

	// flag code is one of the three legal values
	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_flag != szpd_pkg::FLAG_BAD)
		else $error("illegal peak flag code");

	// no flag during warm-up
	a_warm_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ready_res |-> peak_flag == szpd_pkg::FLAG_NONE)
		else $error("flag raised before the window is full");

endmodule

bind smoothed_zscore_peak_detector_core szpd_checker u_szpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.peak_flag (peak_flag),
	.ready_res (ready_res)
);
